// File: hw/rtl/runtime_balancing_task_picker_defines.svh
// assertion macros for the task picker checker
// used by runtime_balancing_task_picker_chk.sv
`ifndef RUNTIME_BALANCING_TASK_PICKER_DEFINES_SVH
`define RUNTIME_BALANCING_TASK_PICKER_DEFINES_SVH

// same-cycle implication
`define RBTP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RBTP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/rbtp_pkg.sv
// types and constants of the runtime balancing task picker
// no dependencies
`timescale 1ns / 1ps

package rbtp_pkg;

  localparam int NUM_TASKS_DEF = 16;
  localparam int MAX_RESULTS   = 16;
  localparam int CNT_W         = $clog2(MAX_RESULTS + 1);
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_REPORT = 2'd1,
    OP_PASS   = 2'd2
  } op_t;

  localparam logic [1:0] SLOT_RUNNING = 2'd1;
  localparam logic [1:0] SLOT_WAITING = 2'd2;

  localparam logic [1:0] RSN_NOTIFY = 2'd0;
  localparam logic [1:0] RSN_TIMER  = 2'd1;
  localparam logic [1:0] RSN_LEAST  = 2'd2;
  localparam logic [1:0] RSN_NONE   = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  task_index;
    logic [1:0]  new_task_mode;
    logic        new_notify;
    logic [31:0] new_period;
    logic [31:0] now;
    logic [31:0] measured_time;
  } in_item_t;

  typedef struct packed {
    logic [3:0] run_index;
    logic [1:0] run_reason;
    logic       last_of_pass;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic        notify;
    logic [31:0] period;
    logic [31:0] start;
    logic [31:0] total;
    logic [31:0] last;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RMW,
    ST_WALK,
    ST_PICK,
    ST_LAST
  } state_t;

endpackage

// File: hw/rtl/runtime_balancing_task_picker.sv
// runtime balancing task picker: slot table in one memory, walked per pass
// depends on rbtp_pkg
`timescale 1ns / 1ps

// channel | dir | handshake        | payload
// in_     | in  | in_valid/ready   | in_item_t  (write, report, pass)
// out_    | out | out_valid/ready  | out_item_t (one per chosen slot, or one empty item if none)
//
// write and report: a read then a write of one table entry
// pass: walk, pick and last states; the walk reads one entry per cycle through the
// memory port and holds while a finished result cannot move to the output register
// rst_n clears control and the per-entry valid bits; unwritten entries read zero
// one item at a time: in_ready is high only in the idle state

module runtime_balancing_task_picker
  import rbtp_pkg::*;
#(
  parameter int NUM_TASKS = NUM_TASKS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

  entry_t mem [NUM_TASKS];
  logic [NUM_TASKS-1:0] vld_r, vld_nxt;

  state_t state_r, state_nxt;
  in_item_t item_r;
  entry_t rdata_r;
  logic rvld_r;
  logic rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t wr_data;

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0] least_r, least_nxt;
  logic [IDX_W-1:0] pick_r, pick_nxt;
  logic have_r, have_nxt;
  logic ovf_r, ovf_nxt;
  logic pend_vld_r, pend_vld_nxt;
  out_item_t pend_r, pend_nxt;
  logic out_vld_r, out_vld_nxt;
  out_item_t out_r, out_nxt;

  entry_t ent;
  logic [31:0] tot;
  logic [31:0] elapsed;
  logic [32:0] sum;
  logic is_notify, is_timer, is_run, room, res_new, out_free, blocked;
  logic idx_ok;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // unwritten entries read as the reset value
  assign ent      = rvld_r ? rdata_r : '0;
  assign tot      = ovf_r ? ent.last : ent.total;
  assign elapsed  = item_r.now - ent.start;
  assign sum      = {1'b0, ent.total} + {1'b0, item_r.measured_time};
  assign room     = (cnt_r != CNT_W'(MAX_RESULTS));
  assign out_free = !out_vld_r || out_ready;
  assign idx_ok   = (32'(in_data.task_index) < NUM_TASKS);

  assign is_notify = (ent.mode == SLOT_WAITING) && ent.notify;
  assign is_timer  = (ent.mode == SLOT_WAITING) && !ent.notify &&
                     (ent.period != '0) && (elapsed > ent.period);
  assign is_run    = (ent.mode == SLOT_RUNNING) && (tot < least_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
      rvld_r  <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      vld_r      <= '0;
      ovf_r      <= 1'b0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      cnt_r      <= '0;
      have_r     <= 1'b0;
      idx_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      vld_r      <= vld_nxt;
      ovf_r      <= ovf_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      cnt_r      <= cnt_nxt;
      have_r     <= have_nxt;
      idx_r      <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    least_r <= least_nxt;
    pick_r  <= pick_nxt;
    pend_r  <= pend_nxt;
    out_r   <= out_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    vld_nxt      = vld_r;
    ovf_nxt      = ovf_r;
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    out_vld_nxt  = out_vld_r && !out_ready;
    out_nxt      = out_r;
    cnt_nxt      = cnt_r;
    have_nxt     = have_r;
    least_nxt    = least_r;
    pick_nxt     = pick_r;
    idx_nxt      = idx_r;
    rd_en        = 1'b0;
    rd_addr      = idx_r;
    wr_en        = 1'b0;
    wr_addr      = idx_r;
    wr_data      = ent;
    res_new      = 1'b0;
    blocked      = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_data.mode) inside
            OP_WRITE, OP_REPORT: begin
              if (idx_ok) begin
                rd_en     = 1'b1;
                rd_addr   = IDX_W'(in_data.task_index);
                idx_nxt   = IDX_W'(in_data.task_index);
                state_nxt = ST_RMW;
              end
            end
            OP_PASS: begin
              rd_en     = 1'b1;
              rd_addr   = '0;
              idx_nxt   = '0;
              cnt_nxt   = '0;
              have_nxt  = 1'b0;
              least_nxt = ALL_ONES;
              state_nxt = ST_WALK;
            end
            default: ;
          endcase
        end
      end

      ST_RMW: begin
        wr_en = 1'b1;
        vld_nxt[idx_r] = 1'b1;
        if (item_r.mode == OP_WRITE) begin
          wr_data.mode   = item_r.new_task_mode;
          wr_data.notify = item_r.new_notify;
          wr_data.period = item_r.new_period;
          wr_data.start  = item_r.now;
        end else begin
          wr_data.last  = item_r.measured_time;
          wr_data.total = sum[31:0];
          if (sum[32]) begin
            ovf_nxt = 1'b1;
          end
        end
        state_nxt = ST_IDLE;
      end

      ST_WALK: begin
        res_new = (is_notify || is_timer) && room;
        blocked = res_new && pend_vld_r && !out_free;
        if (!blocked) begin
          wr_en = 1'b1;
          vld_nxt[idx_r] = 1'b1;
          wr_data.total = tot;
          if (is_timer && room) begin
            wr_data.start = item_r.now;
          end
          if (res_new) begin
            if (pend_vld_r) begin
              out_vld_nxt = 1'b1;
              out_nxt     = pend_r;
            end
            pend_vld_nxt          = 1'b1;
            pend_nxt.run_index    = 4'(idx_r);
            pend_nxt.run_reason   = is_notify ? RSN_NOTIFY : RSN_TIMER;
            pend_nxt.last_of_pass = 1'b0;
            cnt_nxt               = cnt_r + 1'b1;
          end
          if (is_run) begin
            least_nxt = tot;
            pick_nxt  = idx_r;
            have_nxt  = 1'b1;
          end
          if (idx_r == IDX_W'(NUM_TASKS - 1)) begin
            state_nxt = ST_PICK;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_r + 1'b1;
            idx_nxt = idx_r + 1'b1;
          end
        end
      end

      ST_PICK: begin
        res_new = have_r && room;
        blocked = res_new && pend_vld_r && !out_free;
        if (!blocked) begin
          if (res_new) begin
            if (pend_vld_r) begin
              out_vld_nxt = 1'b1;
              out_nxt     = pend_r;
            end
            pend_vld_nxt          = 1'b1;
            pend_nxt.run_index    = 4'(pick_r);
            pend_nxt.run_reason   = RSN_LEAST;
            pend_nxt.last_of_pass = 1'b0;
          end
          state_nxt = ST_LAST;
        end
      end

      ST_LAST: begin
        if (out_free) begin
          out_vld_nxt = 1'b1;
          if (pend_vld_r) begin
            out_nxt = pend_r;
          end else begin
            out_nxt.run_index  = '0;
            out_nxt.run_reason = RSN_NONE;
          end
          out_nxt.last_of_pass = 1'b1;
          pend_vld_nxt = 1'b0;
          ovf_nxt      = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/runtime_balancing_task_picker_chk.sv
// port-level checker for the task picker, bound to the top level
// depends on rbtp_pkg and runtime_balancing_task_picker_defines.svh
`timescale 1ns / 1ps
`include "runtime_balancing_task_picker_defines.svh"

module runtime_balancing_task_picker_sva
  import rbtp_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  `RBTP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result item changed while stalled")

  `RBTP_ASSERT_NOW(a_none_last, clk, rst_n, out_valid && (out_data.run_reason == RSN_NONE), out_data.last_of_pass && (out_data.run_index == 4'd0), "empty pass result malformed")

  `RBTP_ASSERT_NEXT(a_pass_busy, clk, rst_n, in_valid && in_ready && (in_data.mode == OP_PASS), !in_ready, "input taken during a pass")

  `RBTP_ASSERT_NOW(a_busy_on_out, clk, rst_n, out_valid && !out_data.last_of_pass, !in_ready, "new item taken before pass finished")

endmodule

bind runtime_balancing_task_picker runtime_balancing_task_picker_sva u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
